[rtl/core/dli_pkg.sv]
// ----------------------------------------------------------------------------
// dli_pkg
// Shared types, codes and constants of the dense layer inference core,
// including the sigmoid lookup table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package dli_pkg;

    // field widths of the item and result channels, accumulator width and fraction bits
    localparam int DATA_W    = 16;
    localparam int INDEX_W   = 6;
    localparam int CMD_W     = 2;
    localparam int ACC_W     = 40;
    localparam int FRAC_BITS = 8;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [INDEX_W-1:0]       index_t;
    typedef logic [CMD_W-1:0]         cmd_t;

    // item commands
    localparam cmd_t CMD_WEIGHT = 2'd0;
    localparam cmd_t CMD_BIAS   = 2'd1;
    localparam cmd_t CMD_INPUT  = 2'd2;

    // activation modes
    localparam logic [1:0] ACT_RELU    = 2'd0;
    localparam logic [1:0] ACT_SIGMOID = 2'd1;
    localparam logic [1:0] ACT_LEAKY   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_INPUT_LENGTH    = 2'd0;
    localparam logic [1:0] REG_OUTPUT_LENGTH   = 2'd1;
    localparam logic [1:0] REG_ACTIVATION_MODE = 2'd2;
    localparam logic [1:0] REG_LEAK_COEFF      = 2'd3;

    // register reset values
    localparam logic [6:0]  RST_INPUT_LENGTH  = 7'd64;
    localparam logic [6:0]  RST_OUTPUT_LENGTH = 7'd64;
    localparam logic [1:0]  RST_ACT_MODE      = ACT_RELU;
    localparam logic [15:0] RST_LEAK_COEFF    = 16'd655;

    // sigmoid table: 256 entries over [-8,8), Q8.8 values 0..256
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = 8;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

    typedef logic [8:0] sig_entry_t;
    typedef sig_entry_t [SIG_ENTRIES-1:0] sig_rom_t;

    // e^(-k/16) in Q0.32 by repeated multiply, then a shift-subtract divide
    function automatic sig_rom_t build_sig_rom();
        logic [63:0] e [0:128];
        logic [63:0] ek;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] q;
        sig_rom_t    rom;
        e[0] = 64'd1 << 32;
        for (int k = 1; k <= 128; k++) begin
            e[k] = (e[k-1] * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            if (i >= 128) begin
                ek  = e[i-128];
                num = 64'd1 << 40;
            end
            else begin
                ek  = e[128-i];
                num = ek << 8;
            end
            d   = (64'd1 << 32) + ek;
            n   = num + (d >> 1);
            rem = '0;
            q   = '0;
            for (int b = 40; b >= 0; b--) begin
                rem = {rem[62:0], n[b]};
                if (rem >= d) begin
                    rem  = rem - d;
                    q[b] = 1'b1;
                end
            end
            rom[i] = q[8:0];
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

`default_nettype wire

[rtl/core/dli_if.sv]
// ----------------------------------------------------------------------------
// dli_if
// Valid/ready channels of the dense layer inference core: the item channel
// that loads weights, biases and inputs, and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dli_item_if
    import dli_pkg::*;
();
    logic   valid;
    logic   ready;
    cmd_t   command;
    index_t row_index;
    index_t col_index;
    data_t  data_value;

    modport source (output valid, command, row_index, col_index, data_value, input ready);
    modport sink   (input valid, command, row_index, col_index, data_value, output ready);
endinterface

interface dli_result_if
    import dli_pkg::*;
();
    logic   valid;
    logic   ready;
    data_t  out_value;
    index_t out_row;
    logic   out_last;

    modport source (output valid, out_value, out_row, out_last, input ready);
    modport sink   (input valid, out_value, out_row, out_last, output ready);
endinterface

`default_nettype wire

[rtl/core/dense_layer_inference_core.sv]
// ----------------------------------------------------------------------------
// dense_layer_inference_core
// One fully connected layer, out = act(W*x + b), in Q8.8 with a 40-bit
// accumulator, relu, sigmoid or leaky relu activation.
// ----------------------------------------------------------------------------
// Weight, bias and input element transactions are taken one per cycle and
// go straight into single-port synchronous memories. The input element at
// column input_length-1 starts a run: every row is computed by streaming
// its weights and the input vector out of the memories into one multiplier
// and the accumulator, then rounding, saturation and activation follow in a
// short pipeline. The memory read port serves one column per cycle during
// the sweep of a row. No item is taken during a run; item ready returns as
// soon as the last row sits in the output register. Memories are not
// cleared; reading an entry never written gives no defined value.
`default_nettype none

module dense_layer_inference_core
    import dli_pkg::*;
#(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_OUTPUTS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dli_item_if.sink                   item,
    dli_result_if.source               result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int W_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
    localparam int IW  = (MAX_INPUTS > 1)  ? $clog2(MAX_INPUTS)  : 1;
    localparam int OW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int WAW = (W_DEPTH > 1)     ? $clog2(W_DEPTH)     : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    // configuration registers
    logic [6:0]  in_len_reg;
    logic [6:0]  out_len_reg;
    logic [1:0]  act_mode_reg;
    logic [15:0] leak_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    // sequencer
    logic [1:0]     state_reg, state_next;
    logic [IW-1:0]  col_reg, col_next;
    logic [OW-1:0]  row_reg, row_next;
    logic [WAW-1:0] base_reg, base_next;
    logic [IW-1:0]  n_in_m1;
    logic [OW-1:0]  n_out_m1;
    logic [31:0]    in_len_w;
    logic [31:0]    out_len_w;

    // item decode
    logic           item_fire;
    logic           col_ok;
    logic           row_ok;
    logic           w_we;
    logic           b_we;
    logic           x_we;
    logic           run_start;
    logic [31:0]    w_wr_addr_full;

    // memories
    data_t          w_mem [W_DEPTH];
    data_t          b_mem [MAX_OUTPUTS];
    data_t          x_mem [MAX_INPUTS];
    logic [WAW-1:0] w_addr;
    logic [OW-1:0]  b_addr;
    logic [IW-1:0]  x_addr;
    data_t          w_rd_reg;
    data_t          b_rd_reg;
    data_t          x_rd_reg;

    // datapath pipeline
    logic               s1_valid_reg, s1_first_reg, s1_last_reg;
    logic               s2_valid_reg, s2_first_reg, s2_last_reg;
    logic signed [31:0] prod_reg;
    data_t              bias_hold_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_base;
    logic               s3_done_reg;
    logic signed [ACC_W:0]   rnd_sum;
    logic signed [ACC_W:0]   rnd_shift;
    data_t              z_reg;
    logic               s4_done_reg;
    logic signed [DATA_W:0]  sig_off;
    logic [SIG_IDX_W-1:0]    sig_idx;
    data_t              act_reg;
    logic signed [32:0] lprod_reg;
    logic               use_leak_reg;
    logic               s5_done_reg;
    logic signed [33:0] leak_sum;
    logic signed [33:0] leak_shift;
    data_t              leak_val;
    data_t              res_reg;
    logic               push_fire;

    // output register
    logic   out_valid_reg;
    data_t  out_value_reg;
    index_t out_row_reg;
    logic   out_last_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_reg   <= RST_INPUT_LENGTH;
            out_len_reg  <= RST_OUTPUT_LENGTH;
            act_mode_reg <= RST_ACT_MODE;
            leak_reg     <= RST_LEAK_COEFF;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INPUT_LENGTH:    in_len_reg   <= pwdata[6:0];
                REG_OUTPUT_LENGTH:   out_len_reg  <= pwdata[6:0];
                REG_ACTIVATION_MODE: act_mode_reg <= pwdata[1:0];
                REG_LEAK_COEFF:      leak_reg     <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_index)
            REG_INPUT_LENGTH:    prdata = 32'(in_len_reg);
            REG_OUTPUT_LENGTH:   prdata = 32'(out_len_reg);
            REG_ACTIVATION_MODE: prdata = 32'(act_mode_reg);
            REG_LEAK_COEFF:      prdata = 32'(leak_reg);
            default:             prdata = '0;
        endcase
    end

    // clamped lengths, kept as last index
    assign in_len_w  = 32'(in_len_reg);
    assign out_len_w = 32'(out_len_reg);
    assign n_in_m1   = (in_len_w == 32'd0) ? '0 :
                       (in_len_w > 32'(MAX_INPUTS)) ? IW'(MAX_INPUTS - 1) :
                       IW'(in_len_w - 32'd1);
    assign n_out_m1  = (out_len_w == 32'd0) ? '0 :
                       (out_len_w > 32'(MAX_OUTPUTS)) ? OW'(MAX_OUTPUTS - 1) :
                       OW'(out_len_w - 32'd1);

    // item decode
    assign item.ready     = (state_reg == ST_IDLE);
    assign item_fire      = item.valid && item.ready;
    assign col_ok         = 32'(item.col_index) < 32'(MAX_INPUTS);
    assign row_ok         = 32'(item.row_index) < 32'(MAX_OUTPUTS);
    assign w_we           = item_fire && (item.command == CMD_WEIGHT) && row_ok && col_ok;
    assign b_we           = item_fire && (item.command == CMD_BIAS) && row_ok;
    assign x_we           = item_fire && (item.command == CMD_INPUT) && col_ok;
    assign run_start      = x_we && (32'(item.col_index) == 32'(n_in_m1));
    assign w_wr_addr_full = 32'(item.row_index) * 32'(MAX_INPUTS) + 32'(item.col_index);

    // memory addresses: loads while idle, sweep reads during a run
    assign w_addr = (state_reg == ST_IDLE) ? WAW'(w_wr_addr_full)
                                           : WAW'(32'(base_reg) + 32'(col_reg));
    assign b_addr = (state_reg == ST_IDLE) ? OW'(item.row_index) : row_reg;
    assign x_addr = (state_reg == ST_IDLE) ? IW'(item.col_index) : col_reg;

    // weight memory
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_addr] <= item.data_value;
        end
        w_rd_reg <= w_mem[w_addr];
    end

    // bias memory
    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_addr] <= item.data_value;
        end
        b_rd_reg <= b_mem[b_addr];
    end

    // input vector memory
    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[x_addr] <= item.data_value;
        end
        x_rd_reg <= x_mem[x_addr];
    end

    // run sequencer
    assign push_fire = (state_reg == ST_PUSH) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (run_start)
                begin
                    state_next = ST_ISSUE;
                    col_next   = '0;
                    row_next   = '0;
                    base_next  = '0;
                end
            end
            ST_ISSUE:
            begin
                col_next = col_reg + IW'(1);
                if (col_reg == n_in_m1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s5_done_reg)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_fire)
                begin
                    if (row_reg == n_out_m1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        col_next   = '0;
                        row_next   = row_reg + OW'(1);
                        base_next  = WAW'(32'(base_reg) + 32'(MAX_INPUTS));
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
        end
    end

    // pipeline control tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            s3_done_reg  <= 1'b0;
            s4_done_reg  <= 1'b0;
            s5_done_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= (state_reg == ST_ISSUE);
            s1_first_reg <= (state_reg == ST_ISSUE) && (col_reg == '0);
            s1_last_reg  <= (state_reg == ST_ISSUE) && (col_reg == n_in_m1);
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s3_done_reg  <= s2_valid_reg && s2_last_reg;
            s4_done_reg  <= s3_done_reg;
            s5_done_reg  <= s4_done_reg;
        end
    end

    // product stage, bias caught on the first column
    always_ff @(posedge clk)
    begin
        prod_reg <= w_rd_reg * x_rd_reg;
        if (s1_first_reg)
        begin
            bias_hold_reg <= b_rd_reg;
        end
    end

    // accumulate, seeded with the bias in Q24.16
    assign acc_base = s2_first_reg ? {{(ACC_W-DATA_W-FRAC_BITS){bias_hold_reg[DATA_W-1]}},
                                      bias_hold_reg, {FRAC_BITS{1'b0}}}
                                   : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_base + ACC_W'(prod_reg);
        end
    end

    // round to Q8.8 and saturate
    assign rnd_sum   = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(1 << (FRAC_BITS - 1));
    assign rnd_shift = rnd_sum >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (rnd_shift > (ACC_W+1)'(32767))
        begin
            z_reg <= 16'sh7fff;
        end
        else if (rnd_shift < -(ACC_W+1)'(32768))
        begin
            z_reg <= 16'sh8000;
        end
        else
        begin
            z_reg <= DATA_W'(rnd_shift);
        end
    end

    // sigmoid table index, clamped to the table
    assign sig_off = (DATA_W+1)'(z_reg) + (DATA_W+1)'(2048);

    always_comb
    begin
        if (sig_off < 0)
        begin
            sig_idx = '0;
        end
        else if ((sig_off >>> 4) > (DATA_W+1)'(SIG_ENTRIES - 1))
        begin
            sig_idx = SIG_IDX_W'(SIG_ENTRIES - 1);
        end
        else
        begin
            sig_idx = SIG_IDX_W'(sig_off >>> 4);
        end
    end

    // activation stage, leak product registered
    always_ff @(posedge clk)
    begin
        lprod_reg    <= z_reg * $signed({1'b0, leak_reg});
        use_leak_reg <= 1'b0;
        case (act_mode_reg)
            ACT_RELU:    act_reg <= (z_reg > 0) ? z_reg : '0;
            ACT_SIGMOID: act_reg <= DATA_W'(SIG_ROM[sig_idx]);
            default:
            begin
                act_reg      <= z_reg;
                use_leak_reg <= !(z_reg > 0);
            end
        endcase
    end

    // leak scaling with rounding, floor shift
    assign leak_sum   = 34'(lprod_reg) + 34'sd32768;
    assign leak_shift = leak_sum >>> 16;
    assign leak_val   = (leak_shift > 34'sd32767)  ? 16'sh7fff :
                        (leak_shift < -34'sd32768) ? 16'sh8000 : DATA_W'(leak_shift);

    always_ff @(posedge clk)
    begin
        if (s5_done_reg)
        begin
            res_reg <= use_leak_reg ? leak_val : act_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            out_value_reg <= res_reg;
            out_row_reg   <= INDEX_W'(32'(row_reg));
            out_last_reg  <= (row_reg == n_out_m1);
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_value = out_value_reg;
    assign result.out_row   = out_row_reg;
    assign result.out_last  = out_last_reg;

    // read tags only follow sweep cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(state_reg == ST_ISSUE))
        else $error("read tag without a sweep cycle");

    // a finished row passes the s4 and s5 done stages to the activation output while draining
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_done_reg |-> ##2 (s5_done_reg && state_reg == ST_DRAIN))
        else $error("row result out of step with the sequencer");

    // the sweep column never passes the clamped input length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (col_reg <= n_in_m1))
        else $error("column counter past input length");

endmodule

`default_nettype wire

[tb/sv/dense_layer_inference_core_test.sv]
// ----------------------------------------------------------------------------
// dense_layer_inference_core_test
// Self-checking bench for the dense layer core: loads weights, biases and
// input vectors over the item channel, recomputes every activated row in a
// Q8.8 layer model of its own and compares each result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_layer_inference_core_test
    import dli_pkg::*;
;

    localparam int   SETTLE_CYCLES = 16;
    localparam cmd_t CMD_UNUSED    = 2'd3;
    // mode three acts as leaky relu
    localparam logic [1:0] ACT_LEAKY_ALT = 2'd3;

    typedef struct packed {
        data_t  value;
        index_t row;
        logic   last;
    } layer_out_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dli_item_if   items_ch ();
    dli_result_if results_ch ();

    dense_layer_inference_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (items_ch),
        .result  (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // layer model state
    data_t      weight_mem [0:63][0:63];
    bit         weight_set [0:63][0:63];
    data_t      bias_mem   [0:63];
    bit         bias_set   [0:63];
    data_t      input_mem  [0:63];
    bit         input_set  [0:63];
    logic [6:0]  cfg_in_len  = 7'd64;
    logic [6:0]  cfg_out_len = 7'd64;
    logic [1:0]  cfg_act     = ACT_RELU;
    logic [15:0] cfg_leak    = 16'd655;
    logic [8:0]  sig_table [0:255];

    layer_out_t expected_outputs [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int failures        = 0;
    int items_sent      = 0;
    int results_checked = 0;

    // sigmoid table: e^(-k/16) in Q0.32 by repeated multiply, then one divide
    initial begin : sigmoid_table
        logic [95:0] e [0:128];
        logic [95:0] ek;
        logic [95:0] num;
        logic [95:0] d;
        e[0] = 96'd1 << 32;
        for (int k = 1; k <= 128; k++)
        begin
            e[k] = (e[k-1] * 96'd4034748382 + (96'd1 << 31)) >> 32;
        end
        for (int i = 0; i < 256; i++)
        begin
            if (i >= 128)
            begin
                ek  = e[i-128];
                num = 96'd1 << 40;
            end
            else
            begin
                ek  = e[128-i];
                num = ek << 8;
            end
            d = (96'd1 << 32) + ek;
            sig_table[i] = 9'((num + d / 2) / d);
        end
    end

    function automatic int clamp_length(input logic [6:0] v);
        if (v == 0)
            return 1;
        return (v > 64) ? 64 : int'(v);
    endfunction

    function automatic data_t saturate_q88(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return data_t'(v);
    endfunction

    function automatic data_t activate(input data_t z);
        longint scaled;
        int     idx;
        case (cfg_act)
            ACT_RELU:
                return (z > 0) ? z : '0;
            ACT_SIGMOID:
            begin
                idx = (int'(z) + 2048) >>> 4;
                if (idx < 0)
                    idx = 0;
                if (idx > 255)
                    idx = 255;
                return data_t'(sig_table[idx]);
            end
            default:
            begin
                if (z > 0)
                    return z;
                scaled = (longint'(z) * longint'(cfg_leak) + 32768) >>> 16;
                return saturate_q88(scaled);
            end
        endcase
    endfunction

    function automatic logic [31:0] register_value(input logic [1:0] idx);
        case (idx)
            REG_INPUT_LENGTH:    return 32'(cfg_in_len);
            REG_OUTPUT_LENGTH:   return 32'(cfg_out_len);
            REG_ACTIVATION_MODE: return 32'(cfg_act);
            default:             return 32'(cfg_leak);
        endcase
    endfunction

    function automatic data_t rand_value();
        case ($urandom_range(0, 3))
            0:       return data_t'($urandom);
            1:       return data_t'(int'($urandom_range(0, 2047)) - 1024);
            default: return data_t'(int'($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    // update the layer model with one accepted item, queue the rows it yields
    task automatic update_layer_model(input cmd_t cmd, input index_t row, input index_t col,
                                      input data_t value);
        int                 n_in;
        int                 n_out;
        logic signed [39:0] acc;
        longint             z;
        layer_out_t         res;
        case (cmd)
            CMD_WEIGHT:
            begin
                weight_mem[row][col] = value;
                weight_set[row][col] = 1'b1;
            end
            CMD_BIAS:
            begin
                bias_mem[row] = value;
                bias_set[row] = 1'b1;
            end
            CMD_INPUT:
            begin
                input_mem[col] = value;
                input_set[col] = 1'b1;
                n_in  = clamp_length(cfg_in_len);
                n_out = clamp_length(cfg_out_len);
                if (int'(col) == n_in - 1)
                begin
                    for (int r = 0; r < n_out; r++)
                    begin
                        acc = 40'(longint'(bias_mem[r]) * 256);
                        for (int c = 0; c < n_in; c++)
                        begin
                            acc = acc + 40'(longint'(weight_mem[r][c]) * longint'(input_mem[c]));
                        end
                        z         = (longint'(acc) + 128) >>> 8;
                        res.value = activate(saturate_q88(z));
                        res.row   = index_t'(r);
                        res.last  = (r == n_out - 1);
                        expected_outputs.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // one setup and one access phase on the register port, then the port is left idle
    task automatic apb_transfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [31:0] rd;
        apb_transfer(1'b0, idx, '0, rd);
        if (rd !== register_value(idx))
        begin
            $display("%0t: register %0d readback expected %0h actual %0h",
                     $time, idx, register_value(idx), rd);
            failures++;
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_transfer(1'b1, idx, value, rd);
        case (idx)
            REG_INPUT_LENGTH:    cfg_in_len  = value[6:0];
            REG_OUTPUT_LENGTH:   cfg_out_len = value[6:0];
            REG_ACTIVATION_MODE: cfg_act     = value[1:0];
            default:             cfg_leak    = value[15:0];
        endcase
        check_register(idx);
    endtask

    // one item transaction, with a random hold-off before it
    task automatic send_item(input cmd_t cmd, input index_t row, input index_t col,
                             input data_t value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            items_ch.valid <= 1'b0;
            @(posedge clk);
        end
        items_ch.valid      <= 1'b1;
        items_ch.command    <= cmd;
        items_ch.row_index  <= row;
        items_ch.col_index  <= col;
        items_ch.data_value <= value;
        @(posedge clk);
        while (items_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        update_layer_model(cmd, row, col, value);
    endtask

    // hold the item channel until every pending row has come back
    task automatic wait_results_drained();
        items_ch.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stray traffic: loads anywhere, non-final inputs, unused command
    task automatic send_noise_item();
        index_t col;
        col = index_t'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
            0: send_item(CMD_WEIGHT, index_t'($urandom), col, rand_value());
            1: send_item(CMD_BIAS, index_t'($urandom), col, rand_value());
            2:
            begin
                if (int'(col) == clamp_length(cfg_in_len) - 1)
                    col = col + 1'b1;
                send_item(CMD_INPUT, index_t'($urandom), col, rand_value());
            end
            default: send_item(CMD_UNUSED, index_t'($urandom), col, rand_value());
        endcase
    endtask

    // complete load of whatever the current lengths read, then the last input
    task automatic run_load_sequence();
        int n_in;
        int n_out;
        n_in  = clamp_length(cfg_in_len);
        n_out = clamp_length(cfg_out_len);
        for (int r = 0; r < n_out; r++)
        begin
            for (int c = 0; c < n_in; c++)
            begin
                if (!weight_set[r][c] || $urandom_range(0, 1) == 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_noise_item();
                    send_item(CMD_WEIGHT, index_t'(r), index_t'(c), rand_value());
                end
            end
        end
        for (int r = 0; r < n_out; r++)
        begin
            if (!bias_set[r] || $urandom_range(0, 1) == 0)
                send_item(CMD_BIAS, index_t'(r), index_t'($urandom), rand_value());
        end
        for (int c = 0; c < n_in - 1; c++)
        begin
            if (!input_set[c] || $urandom_range(0, 1) == 0)
                send_item(CMD_INPUT, index_t'($urandom), index_t'(c), rand_value());
        end
        send_item(CMD_INPUT, index_t'($urandom), index_t'(n_in - 1), rand_value());
    endtask

    task automatic test_register_reset();
        for (int i = 0; i < 4; i++)
        begin
            check_register(2'(i));
        end
    endtask

    // small 2x6 layer: saturation both ways, sigmoid table edges, every mode
    task automatic test_directed_extremes();
        data_t z_bias [0:5];
        z_bias = '{16'sh7FFF, 16'sh8000, -16'sd2049, 16'sd2048, -16'sd2048, 16'sd2047};
        write_register(REG_INPUT_LENGTH, 32'd2);
        write_register(REG_OUTPUT_LENGTH, 32'd6);
        write_register(REG_ACTIVATION_MODE, 32'(ACT_RELU));
        send_item(CMD_WEIGHT, 6'd0, 6'd0, 16'sh7FFF);
        send_item(CMD_WEIGHT, 6'd0, 6'd1, 16'sh8000);
        send_item(CMD_WEIGHT, 6'd1, 6'd0, 16'sh8000);
        send_item(CMD_WEIGHT, 6'd1, 6'd1, 16'sh7FFF);
        for (int r = 2; r < 6; r++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                send_item(CMD_WEIGHT, index_t'(r), index_t'(c), '0);
            end
        end
        for (int r = 0; r < 6; r++)
        begin
            send_item(CMD_BIAS, index_t'(r), 6'd0, z_bias[r]);
        end
        // unused command must leave everything alone
        send_item(CMD_UNUSED, 6'h3F, 6'h3F, 16'sh7FFF);
        // first element is stored, the last one starts the run
        send_item(CMD_INPUT, 6'd0, 6'd0, 16'sh7FFF);
        send_item(CMD_INPUT, 6'd0, 6'd1, 16'sh8000);
        wait_results_drained();
        write_register(REG_ACTIVATION_MODE, 32'(ACT_SIGMOID));
        send_item(CMD_INPUT, 6'd0, 6'd1, 16'sh8000);
        wait_results_drained();
        write_register(REG_ACTIVATION_MODE, 32'(ACT_LEAKY));
        send_item(CMD_INPUT, 6'd0, 6'd1, 16'sh8000);
        wait_results_drained();
        write_register(REG_LEAK_COEFF, 32'hFFFF);
        send_item(CMD_INPUT, 6'd0, 6'd1, 16'sh8000);
        wait_results_drained();
        write_register(REG_ACTIVATION_MODE, 32'(ACT_LEAKY_ALT));
        write_register(REG_LEAK_COEFF, 32'd0);
        send_item(CMD_INPUT, 6'd0, 6'd1, 16'sh8000);
    endtask

    task automatic test_random_phase(input int in_len, input int out_len, input logic [1:0] mode,
                                     input logic [15:0] leak, input int n_seq);
        wait_results_drained();
        write_register(REG_INPUT_LENGTH, 32'(in_len));
        write_register(REG_OUTPUT_LENGTH, 32'(out_len));
        write_register(REG_ACTIVATION_MODE, 32'(mode));
        write_register(REG_LEAK_COEFF, 32'(leak));
        for (int s = 0; s < n_seq; s++)
        begin
            if ($urandom_range(0, 2) == 0)
                wait_results_drained();
            run_load_sequence();
        end
    endtask

    // result side: random back-pressure, in-order compare of each transaction
    initial begin : result_monitor
        layer_out_t exp_r;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
            begin
                results_checked++;
                if (expected_outputs.size() == 0)
                begin
                    $display("%0t: result row %0d value %0d with nothing expected",
                             $time, results_ch.out_row, results_ch.out_value);
                    failures++;
                end
                else
                begin
                    exp_r = expected_outputs.pop_front();
                    if (results_ch.out_value !== exp_r.value)
                    begin
                        $display("%0t: out_value row %0d expected %0d actual %0d",
                                 $time, exp_r.row, exp_r.value, results_ch.out_value);
                        failures++;
                    end
                    if (results_ch.out_row !== exp_r.row)
                    begin
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, exp_r.row, results_ch.out_row);
                        failures++;
                    end
                    if (results_ch.out_last !== exp_r.last)
                    begin
                        $display("%0t: out_last row %0d expected %0b actual %0b",
                                 $time, exp_r.row, exp_r.last, results_ch.out_last);
                        failures++;
                    end
                end
            end
            results_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    initial begin
        #2000000;
        $display("dense_layer_inference_core verification failed");
        $finish;
    end

    // test sequence
    initial begin
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        items_ch.valid      <= 1'b0;
        items_ch.command    <= CMD_WEIGHT;
        items_ch.row_index  <= '0;
        items_ch.col_index  <= '0;
        items_ch.data_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();

        // slow sender, slow receiver
        send_idle_pct = 23;
        recv_idle_pct = 72;
        test_directed_extremes();
        test_random_phase(3, 4, ACT_SIGMOID, 16'd655, 2);
        test_random_phase(12, 0, ACT_LEAKY, 16'($urandom), 1);

        // roles swapped
        send_idle_pct = 72;
        recv_idle_pct = 23;
        test_random_phase(2, 5, ACT_RELU, 16'($urandom), 2);
        test_random_phase(0, 127, ACT_LEAKY_ALT, 16'($urandom), 1);

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(4, 3, ACT_SIGMOID, 16'($urandom), 2);
        test_random_phase(1, 1, ACT_LEAKY, 16'hFFFF, 3);

        wait_results_drained();
        $display("sent %0d load transactions and checked %0d result transactions",
                 items_sent, results_checked);
        $display("layers from 1x1 up to 12 inputs and up to 64 rows, zero lengths, relu,");
        $display("sigmoid and leaky modes, stalls on both sides");
        if (failures == 0)
            $display("dense_layer_inference_core verification clean");
        else
            $display("dense_layer_inference_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[dense_layer_inference_core.f]
rtl/core/dli_pkg.sv
rtl/core/dli_if.sv
rtl/core/dense_layer_inference_core.sv
tb/sv/dense_layer_inference_core_test.sv
